// ----- hw/rtl/sbod_pkg.sv -----
// Spectrum band onset detector: shared types, constants and helpers.
// No dependencies; imported by every module of the block except sbod_ram.
`default_nettype none
package sbod_pkg;
	localparam int BIN_COUNT_DEF = 64;
	localparam int SQRT_STEPS    = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 15;
	localparam int POS_MAX_W     = 9;

	localparam logic [14:0] RELEASE_RST = 15'd4250;
	localparam logic [14:0] FOLLOW_RST  = 15'd1092;
	localparam logic [1:0]  BAND_RST    = 2'd1;
	localparam logic [14:0] STEP_RST    = 15'd3277;
	localparam logic [7:0]  LOCKOUT_RST = 8'd8;

	localparam logic [14:0] Q15_MAX = 15'h7fff;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RELEASE = 3'd0,
		CFG_FOLLOW  = 3'd1,
		CFG_BAND    = 3'd2,
		CFG_STEP    = 3'd3,
		CFG_LOCKOUT = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BAND_FULL = 2'd0,
		BAND_LOW  = 2'd1,
		BAND_MID  = 2'd2,
		BAND_HIGH = 2'd3
	} band_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_ENV,
		ST_WB,
		ST_DINIT,
		ST_DIV,
		ST_FOLLOW,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic env_mul;
		logic env_wb;
		logic div_start;
		logic div_step;
		logic follow_mul;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic pos_ok;
		logic out_full;
	} status_t;

	// bin range test; full band covers every stored bin
	function automatic logic in_band(input logic [1:0] sel, input logic [POS_MAX_W-1:0] pos);
		logic r;
		r = 1'b0;
		unique case (band_t'(sel))
			BAND_FULL: r = 1'b1;
			BAND_LOW:  r = (pos <= 9'd7);
			BAND_MID:  r = (pos >= 9'd8) && (pos <= 9'd27);
			BAND_HIGH: r = (pos >= 9'd28) && (pos <= 9'd63);
			default:   r = 1'b0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/spectrum_band_onset_detector.sv -----
// Spectrum band onset detector, top level.
// Input stream: s_tdata[15:0] = signed Q0.15 bin magnitude, s_tlast marks
// the last bin of a frame. One result per frame on the output stream.
// Config: write cfg_data to register cfg_index while cfg_we is high
// (0 release, 1 follow, 2 band select, 3 onset step, 4 lockout frames).
// Each bin goes from the accept cycle through the bit-serial square root,
// envelope multiply and envelope write-back before the next transfer.
// Bins past BIN_COUNT are accepted and dropped. The final bin then runs the
// restoring division of the SUM_W-bit band sum (SUM_W = 15 + clog2(BIN_COUNT+1),
// 22 at 64 bins), then the slow-average multiply and onset decision, after which
// the result sits in the output register.
// The output register lets the next frame start while a result waits;
// a frame end finding the register still full waits until it drains.
// Reset clears all envelopes (per-bin valid flags), the slow average and
// arms the onset detector; config registers return to their defaults.
`default_nettype none
module spectrum_band_onset_detector import sbod_pkg::*; #(
	parameter int BIN_COUNT = BIN_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [15:0]           s_tdata,  // magnitude[15:0]
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// band_level[14:0], onset[15], excess[31:16], onset_strength[46:32], pad[47]
	output logic [47:0]                m_tdata
);
	cmd_t    cmd;
	status_t status;

	sbod_ctrl #(.BIN_COUNT(BIN_COUNT)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sbod_dp #(.BIN_COUNT(BIN_COUNT)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_data    (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef NO_ASSERTIONS
	a_rise_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.finish))
		else $error("result appeared without a finish step");
	a_no_accept_in_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !s_tready)
		else $error("input accepted during frame finish");
	a_onset_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[15]) |-> (!m_tdata[31] && (m_tdata[46:32] != 15'd0)))
		else $error("onset with non-positive excess or zero strength");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/sbod_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sbod_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/sbod_ctrl.sv -----
// Sequencer for the onset detector: steps sqrt, envelope, divide, follow.
// Depends on sbod_pkg.
`default_nettype none
module sbod_ctrl import sbod_pkg::*; #(
	parameter int BIN_COUNT = BIN_COUNT_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	input  wire logic    s_tlast,
	output logic         s_tready,
	input  wire status_t status,
	output cmd_t         cmd
);
	localparam int SUM_W = 15 + $clog2(BIN_COUNT + 1);
	localparam int CNT_W = $clog2(SUM_W);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;
	logic             fire;

	assign fire = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					if (status.pos_ok) state_d = ST_SQRT;
					else if (s_tlast) state_d = ST_DINIT;
				end
			end
			ST_SQRT: begin
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = ST_ENV;
			end
			ST_ENV:  state_d = ST_WB;
			ST_WB:   state_d = last_q ? ST_DINIT : ST_IDLE;
			ST_DINIT: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(SUM_W - 1)) state_d = ST_FOLLOW;
			end
			ST_FOLLOW: state_d = ST_FIN;
			ST_FIN: begin
				if (!status.out_full) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		s_tready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = fire;
			end
			ST_SQRT:   cmd.sqrt_step  = 1'b1;
			ST_ENV:    cmd.env_mul    = 1'b1;
			ST_WB:     cmd.env_wb     = 1'b1;
			ST_DINIT:  cmd.div_start  = 1'b1;
			ST_DIV:    cmd.div_step   = 1'b1;
			ST_FOLLOW: cmd.follow_mul = 1'b1;
			ST_FIN:    cmd.finish     = !status.out_full;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) last_q <= s_tlast;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/sbod_dp.sv -----
// Datapath: config registers, sqrt unit, envelope store, band accumulator,
// restoring divider, slow average, onset logic and output register. Uses sbod_pkg, sbod_ram.
`default_nettype none
module sbod_dp import sbod_pkg::*; #(
	parameter int BIN_COUNT = BIN_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [15:0]           s_data,
	input  wire cmd_t                  cmd,
	output status_t                    status,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [47:0]                m_tdata
);
	localparam int ADDR_W = $clog2(BIN_COUNT);
	localparam int POS_W  = $clog2(BIN_COUNT + 1);
	localparam int SUM_W  = 15 + POS_W;

	logic [14:0] release_q, follow_q, step_q;
	logic [1:0]  band_q;
	logic [7:0]  lockout_q;

	logic [POS_W-1:0]     pos_q, cnt_q;
	logic [SUM_W-1:0]     sum_q, dvd_q;
	logic [POS_W-1:0]     drem_q;
	logic [BIN_COUNT-1:0] vld_q;
	logic                 env_vld_q, ge_q;
	logic [30:0]          rem_q, res_q, bit_q;
	logic [29:0]          prod_q;
	logic [14:0]          level_q, ram_rdata, env_cur, root, env_new;
	logic signed [32:0]   fprod_q;
	logic signed [15:0]   slow_q, prev_q;
	logic [7:0]           fso_q;
	logic [47:0]          out_q;
	logic                 out_vld_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_q <= RELEASE_RST;
			follow_q  <= FOLLOW_RST;
			band_q    <= BAND_RST;
			step_q    <= STEP_RST;
			lockout_q <= LOCKOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RELEASE: release_q <= cfg_data;
				CFG_FOLLOW:  follow_q  <= cfg_data;
				CFG_BAND:    band_q    <= cfg_data[1:0];
				CFG_STEP:    step_q    <= cfg_data;
				CFG_LOCKOUT: lockout_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign status.pos_ok   = pos_q < POS_W'(BIN_COUNT);
	assign status.out_full = out_vld_q && !m_tready;

	// sqrt step (one result bit per cycle)
	logic [30:0] trial;
	assign trial = res_q + bit_q;

	assign env_cur = env_vld_q ? ram_rdata : 15'd0;
	assign root    = res_q[14:0];

	logic [29:0] prod_rnd;
	assign prod_rnd = prod_q + 30'd16384;
	assign env_new  = ge_q ? root : env_cur - prod_rnd[29:15];

	sbod_ram #(.WIDTH(15), .DEPTH(BIN_COUNT)) u_env_ram (
		.clk   (clk),
		.we    (cmd.env_wb),
		.waddr (pos_q[ADDR_W-1:0]),
		.wdata (env_new),
		.re    (cmd.load),
		.raddr (pos_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// divider trial
	logic [POS_W:0] dtrial;
	logic           dge;
	assign dtrial = {drem_q, dvd_q[SUM_W-1]};
	assign dge    = dtrial >= {1'b0, cnt_q};

	// follow / onset
	logic [14:0]        level_d;
	logic signed [16:0] delta;
	logic signed [32:0] frnd;
	logic signed [16:0] slow_new, excess;
	logic [7:0]         fso_inc;
	logic               crossed, onset;
	logic [17:0]        s4;
	logic [14:0]        strength;

	assign level_d  = (cnt_q == '0) ? 15'd0 :
		((dvd_q > SUM_W'(Q15_MAX)) ? Q15_MAX : dvd_q[14:0]);
	// level_q loads in the same cycle, so the difference uses the fresh quotient
	assign delta    = $signed({2'b00, level_d}) - $signed({slow_q[15], slow_q});
	assign frnd     = (fprod_q + 33'sd16384) >>> 15;
	assign slow_new = $signed({slow_q[15], slow_q}) + frnd[16:0];
	assign excess   = $signed({2'b00, level_q}) - slow_new;
	assign fso_inc  = (fso_q == 8'hff) ? fso_q : fso_q + 8'd1;
	assign crossed  = ($signed(excess[15:0]) > $signed({1'b0, step_q}))
		&& ($signed(prev_q) <= $signed({1'b0, step_q}));
	assign onset    = crossed && (fso_inc >= lockout_q);
	assign s4       = {excess[15:0], 2'b00};
	assign strength = !onset ? 15'd0 : ((s4 > 18'(Q15_MAX)) ? Q15_MAX : s4[14:0]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q     <= {1'b0, (s_data[15] ? 15'd0 : s_data[14:0]), 15'd0};
			res_q     <= '0;
			bit_q     <= 31'h4000_0000;
			env_vld_q <= vld_q[pos_q[ADDR_W-1:0]];
		end
		if (cmd.sqrt_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.env_mul) begin
			ge_q   <= root >= env_cur;
			prod_q <= (env_cur - root) * release_q;
		end
		if (cmd.div_start) begin
			dvd_q  <= sum_q;
			drem_q <= '0;
		end
		if (cmd.div_step) begin
			drem_q <= dge ? POS_W'(dtrial - {1'b0, cnt_q}) : dtrial[POS_W-1:0];
			dvd_q  <= {dvd_q[SUM_W-2:0], dge};
		end
		if (cmd.follow_mul) begin
			level_q <= level_d;
		end
		if (cmd.follow_mul) begin
			fprod_q <= 33'(delta * $signed({1'b0, follow_q}));
		end
		if (cmd.finish) begin
			out_q <= {1'b0, strength, excess[15:0], onset, level_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			vld_q     <= '0;
			slow_q    <= '0;
			prev_q    <= '0;
			fso_q     <= 8'hff;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.env_wb) begin
				vld_q[pos_q[ADDR_W-1:0]] <= 1'b1;
				pos_q <= pos_q + 1'b1;
				if (in_band(band_q, POS_MAX_W'(pos_q))) begin
					sum_q <= sum_q + SUM_W'(env_new);
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				slow_q    <= slow_new[15:0];
				prev_q    <= excess[15:0];
				fso_q     <= onset ? 8'd0 : fso_inc;
				out_vld_q <= 1'b1;
				pos_q     <= '0;
				sum_q     <= '0;
				cnt_q     <= '0;
			end else if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;
endmodule
`default_nettype wire

// ----- tb/sv/spectrum_band_onset_detector_tb.sv -----
// Self-checking testbench for spectrum_band_onset_detector.
// Depends on sbod_pkg and the RTL; a built-in predictor checks every frame result.
`default_nettype none
module spectrum_band_onset_detector_tb;
	import sbod_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBINS    = 64;
	localparam int WD_LIMIT = 20000;
	localparam int DRAIN_CYC = 80;

	typedef struct {
		logic [15:0] mag;
		logic        last;
	} bin_item_t;

	typedef struct {
		logic [14:0]        level;
		logic               onset;
		logic signed [15:0] excess;
		logic [14:0]        strength;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;

	spectrum_band_onset_detector uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	// predictor state
	int unsigned m_release = 4250, m_follow = 1092, m_band = 1, m_step = 3277, m_lockout = 8;
	int unsigned env[NBINS];
	int unsigned bin_pos = 0, band_acc = 0, band_n = 0, frames_since = 255;
	int slow_avg = 0, prev_excess = 0;

	bin_item_t     pending_bins[$];
	frame_result_t expected_frames[$];
	int errors = 0;
	int bins_accepted = 0;
	int frames_seen = 0;
	int stall_cycles = 0;

	function automatic int unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v) r = t;
		end
		return r[31:0];
	endfunction

	function automatic bit bin_in_band(input int unsigned pos);
		case (band_t'(m_band[1:0]))
			BAND_FULL: return pos < NBINS;
			BAND_LOW:  return pos <= 7;
			BAND_MID:  return pos >= 8 && pos <= 27;
			default:   return pos >= 28 && pos <= 63;
		endcase
	endfunction

	function automatic void predict_bin(input logic [15:0] raw, input logic last);
		int unsigned m, root, e, lvl;
		int dlt, exc, s;
		longint prod;
		bit fire;
		frame_result_t r;
		m = raw[15] ? 0 : raw;
		if (bin_pos < NBINS) begin
			root = int_sqrt(longint'(m) << 15);
			e = env[bin_pos];
			if (root >= e) e = root;
			else e = e - (((e - root) * m_release + 16384) >> 15);
			env[bin_pos] = e;
			if (bin_in_band(bin_pos)) begin
				band_acc += e;
				band_n++;
			end
			bin_pos++;
		end
		if (!last) return;
		lvl = band_n > 0 ? band_acc / band_n : 0;
		if (lvl > 32767) lvl = 32767;
		dlt = int'(lvl) - slow_avg;
		prod = longint'(dlt) * longint'(m_follow) + 16384;
		slow_avg += int'(prod >>> 15);
		exc = int'(lvl) - slow_avg;
		if (frames_since < 255) frames_since++;
		fire = exc > int'(m_step) && prev_excess <= int'(m_step) && frames_since >= m_lockout;
		prev_excess = exc;
		r.level = lvl[14:0];
		r.onset = fire;
		r.excess = exc[15:0];
		r.strength = '0;
		if (fire) begin
			s = exc * 4;
			r.strength = s > 32767 ? 15'h7fff : s[14:0];
			frames_since = 0;
		end
		expected_frames.insert(expected_frames.size(), r);
		bin_pos = 0;
		band_acc = 0;
		band_n = 0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch frame %0d %s: got %0d expected %0d", frames_seen, what, got, want);
		errors++;
	endtask

	// idle regimes: sender 30 / receiver 78, then swapped, then none
	function automatic int sender_idle_pct();
		return bins_accepted < 650 ? 30 : (bins_accepted < 1300 ? 78 : 0);
	endfunction
	function automatic int receiver_idle_pct();
		return bins_accepted < 650 ? 78 : (bins_accepted < 1300 ? 30 : 0);
	endfunction

	// input driver
	bit in_xfer = 1'b0;
	always @(negedge clk) begin
		bin_item_t it;
		if (arst_n && (!s_tvalid || in_xfer)) begin
			if (pending_bins.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
				it = pending_bins.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= it.mag;
				s_tlast <= it.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output ready, with one long hold-off to back the block up
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		if (!hold_done && frames_seen >= 30) begin
			hold_done = 1'b1;
			hold_left = 1500;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
		end
	end

	// monitor, prediction and watchdog
	always @(posedge clk) begin
		frame_result_t w;
		in_xfer = s_tvalid && s_tready;
		if (in_xfer) begin
			predict_bin(s_tdata, s_tlast);
			bins_accepted++;
		end
		if (m_tvalid && m_tready) begin
			if (expected_frames.size() == 0) begin
				report_mismatch("unexpected result, band_level", m_tdata[14:0], -1);
			end else begin
				w = expected_frames.pop_front();
				if (m_tdata[14:0] !== w.level) report_mismatch("band_level", m_tdata[14:0], w.level);
				if (m_tdata[15] !== w.onset) report_mismatch("onset", m_tdata[15], w.onset);
				if (m_tdata[31:16] !== w.excess)
					report_mismatch("excess", $signed(m_tdata[31:16]), w.excess);
				if (m_tdata[46:32] !== w.strength)
					report_mismatch("onset_strength", m_tdata[46:32], w.strength);
			end
			frames_seen++;
		end
		if (in_xfer || (m_tvalid && m_tready) || !arst_n) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= WD_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WD_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic cfg_write(input cfg_idx_t idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RELEASE: m_release = val & 32'h7fff;
			CFG_FOLLOW:  m_follow = val & 32'h7fff;
			CFG_BAND:    m_band = val & 32'h3;
			CFG_STEP:    m_step = val & 32'h7fff;
			default:     m_lockout = val & 32'hff;
		endcase
	endtask

	task automatic set_config(input int unsigned rc, fc, bs, st, lk);
		cfg_write(CFG_RELEASE, rc);
		cfg_write(CFG_FOLLOW, fc);
		cfg_write(CFG_BAND, bs);
		cfg_write(CFG_STEP, st);
		cfg_write(CFG_LOCKOUT, lk);
	endtask

	task automatic push_bin(input logic [15:0] mag, input logic last);
		bin_item_t it;
		it.mag = mag;
		it.last = last;
		pending_bins.insert(pending_bins.size(), it);
	endtask

	// mostly quiet frames with occasional loud bursts so onsets fire
	task automatic build_phase(input int n_items);
		int cnt, len, kind, sel;
		logic [15:0] v;
		cnt = 0;
		while (cnt < n_items) begin
			sel = $urandom_range(0, 15);
			if (sel == 0) len = $urandom_range(1, 4);
			else if (sel == 1) len = NBINS;
			else if (sel == 2) len = $urandom_range(NBINS + 1, NBINS + 8);
			else len = $urandom_range(8, 32);
			kind = $urandom_range(0, 9);
			for (int i = 0; i < len; i++) begin
				if (kind < 6) begin
					v = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(32768, 65535))
						: 16'($urandom_range(0, 400));
				end else if (kind < 8) begin
					v = 16'($urandom_range(16000, 32767));
				end else begin
					v = 16'($urandom);
				end
				push_bin(v, i == len - 1);
			end
			cnt += len;
		end
	endtask

	task automatic wait_drained();
		while (!(pending_bins.size() == 0 && !s_tvalid && expected_frames.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < NBINS; i++) env[i] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset defaults: extremes, negatives, one-bin frame
		push_bin(16'h7fff, 1'b0);
		push_bin(16'h8000, 1'b0);
		push_bin(16'h0001, 1'b1);
		push_bin(16'h0000, 1'b0);
		push_bin(16'hffff, 1'b1);
		push_bin(16'h7fff, 1'b1);
		for (int i = 0; i < 9; i++) push_bin(16'h7fff, i == 8);
		for (int i = 0; i < 9; i++) push_bin(16'h0000, i == 8);
		wait_drained();

		set_config(0, 32767, BAND_FULL, 0, 1);
		build_phase(380);
		wait_drained();
		// high band with short frames also yields empty bands
		set_config(32767, 0, BAND_HIGH, 32767, 255);
		build_phase(380);
		wait_drained();
		set_config(16384, 8000, BAND_MID, 1000, 2);
		build_phase(380);
		wait_drained();
		set_config(4250, 1092, BAND_LOW, 3277, 8);
		build_phase(380);
		wait_drained();
		set_config($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 3),
			$urandom_range(0, 8000), $urandom_range(1, 255));
		build_phase(360);
		wait_drained();

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/sbod_pkg.sv
hw/rtl/sbod_ram.sv
hw/rtl/sbod_ctrl.sv
hw/rtl/sbod_dp.sv
hw/rtl/spectrum_band_onset_detector.sv
tb/sv/spectrum_band_onset_detector_tb.sv
